// File: rtl/grid_maze_bfs_distance_assert.svh
// ----------------------------------------------------------------------------
// grid_maze_bfs_distance_assert.svh
// Assertion macros for the maze search RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_BFS_DISTANCE_ASSERT_SVH
`define GRID_MAZE_BFS_DISTANCE_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define GMB_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("maze search: invariant violated");

// Antecedent in one cycle implies consequent in the next.
`define GMB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("maze search: sequence violated");

`endif

// File: rtl/gmb_pkg.sv
// ----------------------------------------------------------------------------
// gmb_pkg
// Shared types and constants of the grid maze distance search.
// ----------------------------------------------------------------------------
`default_nettype none

package gmb_pkg;

    localparam logic       ACT_LOAD        = 1'b0;
    localparam logic       ACT_QUERY       = 1'b1;
    localparam logic       REG_GRID_SIZE   = 1'b0;
    localparam logic [5:0] GRID_SIZE_RESET = 6'd32;
    localparam logic [9:0] DIST_MAX        = 10'd1023;

    // Sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIVIDE = 5'b00010,
        ST_SEARCH = 5'b00100,
        ST_DONE   = 5'b01000,
        ST_SEED   = 5'b10000
    } state_t;

    // Control from the sequencer to every row cell
    typedef struct packed {
        logic load;   // write one wall bit
        logic seed;   // clear reached bits, set the start cell
        logic step;   // advance the wavefront by one level
    } cell_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/gmb_if.sv
// ----------------------------------------------------------------------------
// gmb_req_if / gmb_rsp_if
// Valid/ready channels for maze items and distance results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmb_req_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [4:0] cell_row;
    logic [4:0] cell_col;
    logic       is_wall;
    logic [9:0] start_cell;
    logic [9:0] goal_cell;

    modport source (output valid, action, cell_row, cell_col, is_wall, start_cell,
                    goal_cell, input ready);
    modport sink (input valid, action, cell_row, cell_col, is_wall, start_cell,
                  goal_cell, output ready);
endinterface

interface gmb_rsp_if;
    logic       valid;
    logic       ready;
    logic [9:0] distance;
    logic       reached;

    modport source (output valid, distance, reached, input ready);
    modport sink (input valid, distance, reached, output ready);
endinterface

`default_nettype wire

// File: rtl/gmb_row_cell.sv
// ----------------------------------------------------------------------------
// gmb_row_cell
// One maze row: wall bits, reached bits and one-level wavefront growth.
// ----------------------------------------------------------------------------
`default_nettype none

module gmb_row_cell
    import gmb_pkg::*;
#(
    parameter int GRID_MAX = 32,
    parameter int ROW      = 0,
    parameter int RW       = 5
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic [RW-1:0]       wr_row,
    input  wire logic [RW-1:0]       wr_col,
    input  wire logic                wr_wall,
    input  wire logic [RW-1:0]       seed_row,
    input  wire logic [RW-1:0]       seed_col,
    input  wire logic                row_ok,
    input  wire logic [GRID_MAX-1:0] col_mask,
    input  wire logic [GRID_MAX-1:0] up_src,
    input  wire logic [GRID_MAX-1:0] dn_src,
    output logic [GRID_MAX-1:0]      src,
    output logic [GRID_MAX-1:0]      reached,
    output logic                     changed
);

    logic [GRID_MAX-1:0] wall_reg;
    logic [GRID_MAX-1:0] reached_reg;
    logic [GRID_MAX-1:0] reached_next;
    logic [GRID_MAX-1:0] spread;
    logic [GRID_MAX-1:0] seed_bits;

    // Only open reached cells pass the wave on
    assign src     = reached_reg & ~wall_reg;
    assign reached = reached_reg;

    // Neighbors above, below, left and right
    always_comb
    begin
        spread       = up_src | dn_src | (src << 1) | (src >> 1);
        reached_next = reached_reg | (spread & ~wall_reg & col_mask & {GRID_MAX{row_ok}});
        seed_bits    = '0;
        if (seed_row == RW'(ROW))
        begin
            seed_bits[seed_col] = 1'b1;
        end
    end

    assign changed = (reached_next != reached_reg);

    // Wall storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wall_reg <= '0;
        end
        else if (ctrl.load && (wr_row == RW'(ROW)))
        begin
            wall_reg[wr_col] <= wr_wall;
        end
    end

    // Reached bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reached_reg <= '0;
        end
        else if (ctrl.seed)
        begin
            reached_reg <= seed_bits;
        end
        else if (ctrl.step)
        begin
            reached_reg <= reached_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/grid_maze_bfs_distance.sv
// ----------------------------------------------------------------------------
// grid_maze_bfs_distance
// Shortest step count between two cells of a square wall/open maze.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: action 0 writes one wall bit (no result), action 1 asks for
//   the distance from start_cell to goal_cell; one result per query on rsp.
//   APB register 0 (byte 0) holds grid_size; write it only while idle.
//   Steps: a load writes its wall bit when it is taken. A query first turns
//   its flat indices into row and column by repeated subtraction, then seeds
//   the start cell, then grows the wavefront level by level until the goal
//   is reached (or until the wave stops growing), and then posts the
//   result. An index outside the maze goes straight to posting. The row cell
//   chain grows the wave by one level each cycle.
//   Reset: all cells open, grid_size 32, no result pending.
//   A stalled receiver holds the result in the output register; loads are
//   still taken meanwhile, a following query is searched but its result
//   waits in the sequencer, and no item is taken until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_maze_bfs_distance
    import gmb_pkg::*;
#(
    parameter int GRID_MAX = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    gmb_req_if.sink          req,
    gmb_rsp_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

`include "grid_maze_bfs_distance_assert.svh"

    localparam int RW = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;

    state_t          state_reg;
    logic [5:0]      grid_size_reg;
    logic [9:0]      start_rem_reg;
    logic [9:0]      goal_rem_reg;
    logic [RW-1:0]   start_row_reg;
    logic [RW-1:0]   goal_row_reg;
    logic [9:0]      level_reg;
    logic [9:0]      res_dist_reg;
    logic            res_reached_reg;
    logic            out_valid_reg;
    logic [9:0]      out_dist_reg;
    logic            out_reached_reg;

    logic [7:0]      n_eff;
    logic [15:0]     total;
    logic            req_fire;
    logic            start_more;
    logic            goal_more;
    logic            goal_hit;
    logic            any_change;
    logic            row_in;
    logic            post_fire;
    logic [RW-1:0]   goal_col;
    cell_ctrl_t      ctrl;
    logic [GRID_MAX-1:0] col_mask;
    logic [GRID_MAX-1:0] row_mask;
    logic [GRID_MAX-1:0] changed_w;
    logic [GRID_MAX-1:0] src_w     [GRID_MAX];
    logic [GRID_MAX-1:0] reached_w [GRID_MAX];

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_GRID_SIZE) ? {26'd0, grid_size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_GRID_SIZE))
        begin
            grid_size_reg <= pwdata[5:0];
        end
    end

    // Effective side length and cell count
    assign n_eff = ({26'd0, grid_size_reg} > GRID_MAX) ? 8'(GRID_MAX) : {2'd0, grid_size_reg};
    assign total = 16'(n_eff) * 16'(n_eff);

    // Masks of live rows and columns
    always_comb
    begin
        for (int i = 0; i < GRID_MAX; i++)
        begin
            col_mask[i] = (i < int'(n_eff));
            row_mask[i] = (i < int'(n_eff));
        end
    end

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign row_in     = ({27'd0, req.cell_row} < GRID_MAX) && ({27'd0, req.cell_col} < GRID_MAX);
    assign start_more = (start_rem_reg >= {2'd0, n_eff});
    assign goal_more  = (goal_rem_reg >= {2'd0, n_eff});
    assign goal_col   = RW'(goal_rem_reg);
    assign goal_hit   = reached_w[goal_row_reg][goal_col];
    assign any_change = |changed_w;
    assign post_fire  = (state_reg == ST_DONE) && (!out_valid_reg || rsp.ready);

    // Cell controls
    always_comb
    begin
        ctrl.load = req_fire && (req.action == ACT_LOAD) && row_in;
        ctrl.seed = (state_reg == ST_SEED);
        ctrl.step = (state_reg == ST_SEARCH) && !goal_hit && any_change;
    end

    // Chain of row cells, each trading its wave front with its neighbor rows
    for (genvar g = 0; g < GRID_MAX; g++)
    begin : g_row
        logic [GRID_MAX-1:0] up_w;
        logic [GRID_MAX-1:0] dn_w;

        if (g == 0)
        begin : g_top
            assign up_w = '0;
        end
        else
        begin : g_mid_up
            assign up_w = src_w[g-1];
        end

        if (g == GRID_MAX - 1)
        begin : g_bot
            assign dn_w = '0;
        end
        else
        begin : g_mid_dn
            assign dn_w = src_w[g+1];
        end

        gmb_row_cell #(
            .GRID_MAX (GRID_MAX),
            .ROW      (g),
            .RW       (RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_row   (RW'(req.cell_row)),
            .wr_col   (RW'(req.cell_col)),
            .wr_wall  (req.is_wall),
            .seed_row (start_row_reg),
            .seed_col (RW'(start_rem_reg)),
            .row_ok   (row_mask[g]),
            .col_mask (col_mask),
            .up_src   (up_w),
            .dn_src   (dn_w),
            .src      (src_w[g]),
            .reached  (reached_w[g]),
            .changed  (changed_w[g])
        );
    end

    // Query sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire && (req.action == ACT_QUERY))
                    begin
                        if (({6'd0, req.start_cell} >= total) || ({6'd0, req.goal_cell} >= total))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    if (!start_more && !goal_more)
                    begin
                        state_reg <= ST_SEED;
                    end
                end
                ST_SEED:
                begin
                    state_reg <= ST_SEARCH;
                end
                ST_SEARCH:
                begin
                    if (goal_hit || !any_change)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Index split, level count and result capture
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                start_rem_reg   <= req.start_cell;
                goal_rem_reg    <= req.goal_cell;
                start_row_reg   <= '0;
                goal_row_reg    <= '0;
                res_dist_reg    <= '0;
                res_reached_reg <= 1'b0;
            end
            ST_DIVIDE:
            begin
                if (start_more)
                begin
                    start_rem_reg <= start_rem_reg - {2'd0, n_eff};
                    start_row_reg <= start_row_reg + 1'b1;
                end
                if (goal_more)
                begin
                    goal_rem_reg <= goal_rem_reg - {2'd0, n_eff};
                    goal_row_reg <= goal_row_reg + 1'b1;
                end
                level_reg <= '0;
            end
            ST_SEARCH:
            begin
                if (goal_hit)
                begin
                    res_dist_reg    <= level_reg;
                    res_reached_reg <= 1'b1;
                end
                else if (level_reg != DIST_MAX)
                begin
                    level_reg <= level_reg + 10'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (post_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_fire)
        begin
            out_dist_reg    <= res_dist_reg;
            out_reached_reg <= res_reached_reg;
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.distance = out_dist_reg;
    assign rsp.reached  = out_reached_reg;

    // Checks
    `GMB_ASSERT_ALWAYS(a_unreached_zero, !rsp.valid || rsp.reached || (rsp.distance == 10'd0))
    `GMB_ASSERT_ALWAYS(a_busy_no_take, (state_reg != ST_SEARCH) || !req.ready)
    `GMB_ASSERT_NEXT(a_done_posts, post_fire, out_valid_reg && (state_reg == ST_IDLE))

endmodule

`default_nettype wire
